// ===== hw/rtl/alci_pkg.sv =====
package alci_pkg;

	// defaults for the top-level parameters
	localparam int LED_TOTAL_DEF     = 100;
	localparam int BUTTON_TOTAL_DEF  = 100;
	localparam int LINE_CAPACITY_DEF = 64;

	// depth of the job queue between front and back
	localparam int JOB_QUEUE_DEPTH = 2;

	// characters the front looks at
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// id magnitude saturates here
	localparam logic [9:0] ID_SATURATE = 10'd1000;

	// command words, one row each, unused tail bytes zero
	localparam int NUM_WORDS = 9;
	localparam int W_PING    = 0;
	localparam int W_VERSION = 1;
	localparam int W_HELP    = 2;
	localparam int W_STATUS  = 3;
	localparam int W_LEDCLR  = 4;
	localparam int W_LEDALL  = 5;
	localparam int W_LEDSET  = 6;
	localparam int W_LEDON   = 7;
	localparam int W_LEDOFF  = 8;

	localparam logic [7:0] WORD_TEXT [NUM_WORDS][8] = '{
		'{"P", "I", "N", "G", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"V", "E", "R", "S", "I", "O", "N", CH_NUL},
		'{"H", "E", "L", "P", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"S", "T", "A", "T", "U", "S", CH_NUL, CH_NUL},
		'{"L", "E", "D", "C", "L", "R", CH_NUL, CH_NUL},
		'{"L", "E", "D", "A", "L", "L", CH_NUL, CH_NUL},
		'{"L", "E", "D", "S", "E", "T", CH_SPACE, CH_NUL},
		'{"L", "E", "D", "O", "N", CH_SPACE, CH_NUL, CH_NUL},
		'{"L", "E", "D", "O", "F", "F", CH_SPACE, CH_NUL}
	};

	localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
		4'd4, 4'd7, 4'd4, 4'd6, 4'd6, 4'd6, 4'd7, 4'd6, 4'd7
	};

	// id field start for the prefixed commands
	localparam int ID_START_SHORT = 6;
	localparam int ID_START_LONG  = 7;

	// reply codes
	typedef enum logic [3:0] {
		RC_PONG       = 4'd0,
		RC_OK         = 4'd1,
		RC_INVALID_ID = 4'd2,
		RC_UNKNOWN    = 4'd3,
		RC_VERSION    = 4'd4,
		RC_HELP       = 4'd5,
		RC_STATUS     = 4'd6,
		RC_PRESS      = 4'd7,
		RC_RELEASE    = 4'd8
	} reply_t;

	// led commands
	typedef enum logic [2:0] {
		LC_CLEAR = 3'd0,
		LC_ALL   = 3'd1,
		LC_SET   = 3'd2,
		LC_ON    = 3'd3,
		LC_OFF   = 3'd4
	} led_cmd_t;

	// classified jobs handed from front to back
	typedef enum logic [3:0] {
		OP_PING,
		OP_VERSION,
		OP_HELP,
		OP_STATUS,
		OP_LEDCLR,
		OP_LEDALL,
		OP_LEDSET,
		OP_LEDON,
		OP_LEDOFF,
		OP_UNKNOWN,
		OP_PRESS,
		OP_RELEASE
	} job_op_t;

	typedef struct packed {
		job_op_t    op;
		logic       id_ok;
		logic [7:0] id;
	} job_t;

	// id parser, one byte a step
	typedef enum logic [2:0] {
		PS_SKIP   = 3'b001,
		PS_DIGITS = 3'b010,
		PS_DONE   = 3'b100
	} parse_phase_t;

	typedef struct packed {
		parse_phase_t phase;
		logic         neg;
		logic [9:0]   mag;
	} parse_t;

	localparam parse_t PARSE_INIT = '{phase: PS_SKIP, neg: 1'b0, mag: 10'd0};

	function automatic parse_t parse_step(parse_t s, logic [7:0] c);
		parse_t      n;
		logic        is_dig;
		logic        is_ws;
		logic [7:0]  digit;
		logic [13:0] acc;
		n      = s;
		is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
		is_ws  = (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
		digit  = c - CH_ZERO;
		acc    = ({4'd0, s.mag} * 14'd10) + {6'd0, digit};
		unique case (s.phase)
			PS_SKIP: begin
				if (is_ws) begin
					n.phase = PS_SKIP;
				end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
					n.neg   = (c == CH_MINUS);
					n.phase = PS_DIGITS;
				end else if (is_dig) begin
					n.mag   = {2'd0, digit};
					n.phase = PS_DIGITS;
				end else begin
					n.phase = PS_DONE;
				end
			end
			PS_DIGITS: begin
				if (is_dig) begin
					n.mag = (acc > {4'd0, ID_SATURATE}) ? ID_SATURATE : acc[9:0];
				end else begin
					n.phase = PS_DONE;
				end
			end
			PS_DONE: begin
				n = s;
			end
			default: begin
				n = s;
			end
		endcase
		return n;
	endfunction

endpackage

// ===== hw/rtl/alci_front.sv =====
module alci_front import alci_pkg::*; #(
	parameter int LED_TOTAL     = LED_TOTAL_DEF,
	parameter int BUTTON_TOTAL  = BUTTON_TOTAL_DEF,
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       opcode,
	input  logic [7:0] rx_byte,
	input  logic       event_changed,
	input  logic [7:0] event_button,
	output logic       job_valid,
	output job_t       job,
	input  logic       job_full
);

	localparam int DEPTH  = LINE_CAPACITY - 1;
	localparam int LEN_W  = $clog2(LINE_CAPACITY);
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [2:0] {
		FS_IDLE = 3'b001,
		FS_WALK = 3'b010,
		FS_FIN  = 3'b100
	} front_state_t;

	front_state_t         state_q;
	logic [LEN_W-1:0]     line_len_q;
	logic [LEN_W-1:0]     rd_addr_q;
	logic [LEN_W-1:0]     eff_len_q;
	logic                 rd_valid_s1;
	logic [LEN_W-1:0]     rd_pos_s1;
	logic [7:0]           rd_data_s1;
	logic [NUM_WORDS-1:0] match_q;
	parse_t               par_short_q;
	parse_t               par_long_q;
	logic [7:0]           line_mem [DEPTH];

	logic accept;
	logic is_term;
	logic has_room;
	logic start_walk;
	logic store_byte;
	logic rd_issue;
	logic eval;
	logic eval_zero;
	logic eval_last;
	logic btn_in_range;
	logic id_ok_short;
	logic id_ok_long;
	job_t line_job;

	// input handshake
	assign full       = (state_q != FS_IDLE) | job_full;
	assign accept     = push & ~full;
	assign is_term    = (rx_byte == CH_LF) || (rx_byte == CH_CR);
	assign has_room   = line_len_q < LEN_W'(DEPTH);
	assign start_walk = accept & ~opcode & is_term & (line_len_q != '0);
	assign store_byte = accept & ~opcode & ~is_term & has_room;

	// walk pipeline controls
	assign rd_issue  = (state_q == FS_WALK) && (rd_addr_q < line_len_q);
	assign eval      = (state_q == FS_WALK) && rd_valid_s1;
	assign eval_zero = rd_data_s1 == CH_NUL;
	assign eval_last = eval && (eval_zero || ((rd_pos_s1 + 1'b1) == line_len_q));

	// line memory
	always_ff @(posedge clk) begin
		if (store_byte) begin
			line_mem[line_len_q[ADDR_W-1:0]] <= rx_byte;
		end
		if (rd_issue) begin
			rd_data_s1 <= line_mem[rd_addr_q[ADDR_W-1:0]];
			rd_pos_s1  <= rd_addr_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FS_IDLE;
			line_len_q  <= '0;
			rd_addr_q   <= '0;
			rd_valid_s1 <= 1'b0;
			eff_len_q   <= '0;
		end else begin
			unique case (state_q)
				FS_IDLE: begin
					if (start_walk) begin
						state_q     <= FS_WALK;
						rd_addr_q   <= '0;
						rd_valid_s1 <= 1'b0;
					end else if (accept && !opcode && !is_term) begin
						line_len_q <= has_room ? (line_len_q + 1'b1) : '0;
					end
				end
				FS_WALK: begin
					rd_valid_s1 <= rd_issue;
					if (rd_issue) begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
					if (eval_last) begin
						state_q   <= FS_FIN;
						eff_len_q <= eval_zero ? rd_pos_s1 : line_len_q;
					end
				end
				FS_FIN: begin
					if (!job_full) begin
						state_q    <= FS_IDLE;
						line_len_q <= '0;
					end
				end
				default: begin
					state_q <= FS_IDLE;
				end
			endcase
		end
	end

	// word match flags and id parsers, one byte a cycle
	always_ff @(posedge clk) begin
		if (start_walk) begin
			match_q     <= '1;
			par_short_q <= PARSE_INIT;
			par_long_q  <= PARSE_INIT;
		end else if (eval && !eval_zero) begin
			for (int w = 0; w < NUM_WORDS; w++) begin
				if (rd_pos_s1 < LEN_W'(WORD_LEN[w])) begin
					match_q[w] <= match_q[w] &
						(rd_data_s1 == WORD_TEXT[w][rd_pos_s1[2:0]]);
				end
			end
			if (rd_pos_s1 >= LEN_W'(ID_START_SHORT)) begin
				par_short_q <= parse_step(par_short_q, rd_data_s1);
			end
			if (rd_pos_s1 >= LEN_W'(ID_START_LONG)) begin
				par_long_q <= parse_step(par_long_q, rd_data_s1);
			end
		end
	end

	// id range checks
	assign id_ok_short = !par_short_q.neg && (par_short_q.mag != '0) &&
		(par_short_q.mag <= 10'(LED_TOTAL));
	assign id_ok_long  = !par_long_q.neg && (par_long_q.mag != '0) &&
		(par_long_q.mag <= 10'(LED_TOTAL));

	// classify a finished line
	always_comb begin
		line_job.op    = OP_UNKNOWN;
		line_job.id_ok = 1'b0;
		line_job.id    = '0;
		if (match_q[W_PING] && (eff_len_q == LEN_W'(WORD_LEN[W_PING]))) begin
			line_job.op = OP_PING;
		end else if (match_q[W_VERSION] &&
			(eff_len_q == LEN_W'(WORD_LEN[W_VERSION]))) begin
			line_job.op = OP_VERSION;
		end else if (match_q[W_HELP] && (eff_len_q == LEN_W'(WORD_LEN[W_HELP]))) begin
			line_job.op = OP_HELP;
		end else if (match_q[W_STATUS] &&
			(eff_len_q == LEN_W'(WORD_LEN[W_STATUS]))) begin
			line_job.op = OP_STATUS;
		end else if (match_q[W_LEDCLR] &&
			(eff_len_q == LEN_W'(WORD_LEN[W_LEDCLR]))) begin
			line_job.op = OP_LEDCLR;
		end else if (match_q[W_LEDALL] &&
			(eff_len_q == LEN_W'(WORD_LEN[W_LEDALL]))) begin
			line_job.op = OP_LEDALL;
		end else if (match_q[W_LEDSET] &&
			(eff_len_q >= LEN_W'(WORD_LEN[W_LEDSET]))) begin
			line_job.op    = OP_LEDSET;
			line_job.id_ok = id_ok_long;
			line_job.id    = par_long_q.mag[7:0];
		end else if (match_q[W_LEDON] &&
			(eff_len_q >= LEN_W'(WORD_LEN[W_LEDON]))) begin
			line_job.op    = OP_LEDON;
			line_job.id_ok = id_ok_short;
			line_job.id    = par_short_q.mag[7:0];
		end else if (match_q[W_LEDOFF] &&
			(eff_len_q >= LEN_W'(WORD_LEN[W_LEDOFF]))) begin
			line_job.op    = OP_LEDOFF;
			line_job.id_ok = id_ok_long;
			line_job.id    = par_long_q.mag[7:0];
		end
	end

	// job output: button events straight away, lines after the walk
	assign btn_in_range = (event_button != 8'd0) && (event_button <= 8'(BUTTON_TOTAL));

	always_comb begin
		job_valid = 1'b0;
		job       = line_job;
		if (state_q == FS_FIN) begin
			job_valid = eff_len_q != '0;
		end else if (accept && opcode && event_changed) begin
			job_valid = 1'b1;
			job.op    = btn_in_range ? OP_PRESS : OP_RELEASE;
			job.id_ok = btn_in_range;
			job.id    = event_button;
		end
	end

endmodule

// ===== hw/rtl/alci_fifo.sv =====
module alci_fifo import alci_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic take,
	output job_t head_job,
	output logic empty
);

	localparam int PTR_W = $clog2(JOB_QUEUE_DEPTH);
	localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

	job_t             slot_q [JOB_QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_take;

	assign full     = count_q == CNT_W'(JOB_QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push & ~full;
	assign do_take  = take & ~empty;
	assign head_job = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_take) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_take) begin
				count_q <= count_q + 1'b1;
			end else if (do_take && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/alci_back.sv =====
module alci_back import alci_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       job_empty,
	input  job_t       job,
	output logic       job_take,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] reply_code,
	output logic       led_cmd_valid,
	output logic [2:0] led_cmd,
	output logic [7:0] led_target,
	output logic [7:0] report_id
);

	logic       sink_q;
	logic [7:0] active_q;
	logic       out_valid_q;
	logic [3:0] reply_q;
	logic       led_valid_q;
	logic [2:0] led_cmd_q;
	logic [7:0] led_target_q;
	logic [7:0] report_q;

	logic       has_res;
	reply_t     res_reply;
	logic       res_led_valid;
	led_cmd_t   res_led_cmd;
	logic [7:0] res_target;
	logic [7:0] res_report;
	logic [7:0] active_next;

	// take a job when the output word is free or leaving
	assign job_take = ~job_empty & (~out_valid_q | pop);

	// carry out one job
	always_comb begin
		has_res       = 1'b1;
		res_reply     = RC_UNKNOWN;
		res_led_valid = 1'b0;
		res_led_cmd   = LC_CLEAR;
		res_target    = '0;
		res_report    = '0;
		active_next   = active_q;
		unique case (job.op) inside
			OP_PING: begin
				res_reply = RC_PONG;
			end
			OP_VERSION: begin
				res_reply = RC_VERSION;
			end
			OP_HELP: begin
				res_reply = RC_HELP;
			end
			OP_STATUS: begin
				res_reply  = RC_STATUS;
				res_report = active_q;
			end
			OP_LEDCLR: begin
				res_reply     = RC_OK;
				res_led_valid = sink_q;
				res_led_cmd   = LC_CLEAR;
				if (sink_q) begin
					active_next = '0;
				end
			end
			OP_LEDALL: begin
				res_reply     = RC_OK;
				res_led_valid = sink_q;
				res_led_cmd   = sink_q ? LC_ALL : LC_CLEAR;
			end
			OP_LEDSET, OP_LEDON, OP_LEDOFF: begin
				if (!job.id_ok) begin
					res_reply = RC_INVALID_ID;
				end else begin
					res_reply     = RC_OK;
					res_led_valid = sink_q;
					res_target    = job.id;
					if (sink_q) begin
						if (job.op == OP_LEDSET) begin
							res_led_cmd = LC_SET;
							active_next = job.id;
						end else if (job.op == OP_LEDON) begin
							res_led_cmd = LC_ON;
						end else begin
							res_led_cmd = LC_OFF;
						end
					end
				end
			end
			OP_UNKNOWN: begin
				res_reply = RC_UNKNOWN;
			end
			OP_PRESS: begin
				res_reply   = RC_PRESS;
				res_report  = job.id;
				active_next = job.id;
			end
			OP_RELEASE: begin
				res_reply   = RC_RELEASE;
				res_report  = active_q;
				has_res     = active_q != '0;
				active_next = '0;
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	// config, active id and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_q      <= 1'b1;
			active_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sink_q <= cfg_wr_data;
			end
			if (job_take) begin
				active_q <= active_next;
			end
			if (job_take && has_res) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (job_take && has_res) begin
			reply_q      <= res_reply;
			led_valid_q  <= res_led_valid;
			led_cmd_q    <= res_led_cmd;
			led_target_q <= res_target;
			report_q     <= res_report;
		end
	end

	assign empty         = ~out_valid_q;
	assign reply_code    = reply_q;
	assign led_cmd_valid = led_valid_q;
	assign led_cmd       = led_cmd_q;
	assign led_target    = led_target_q;
	assign report_id     = report_q;

endmodule

// ===== hw/rtl/ascii_led_command_interpreter.sv =====
// channel   ports                                          handshake
// input     opcode rx_byte event_changed event_button      push / full
// result    reply_code led_cmd_valid led_cmd led_target    empty / pop
//           report_id
// config    cfg_wr_data                                    cfg_wr_en
//
// A byte or button event is taken when push is high and full is low. A line end
// walks the line memory one byte a cycle, so full stays high through the walk and
// until the line's job enters the job queue. The back end handles one queued job a
// cycle into a one-word output while that word is free or being popped.
// Reset clears the line length and the active id and sets the sink present bit;
// the line memory is not cleared. A stalled result fills the job queue, after
// which full rises.
module ascii_led_command_interpreter import alci_pkg::*; #(
	parameter int LED_TOTAL     = LED_TOTAL_DEF,
	parameter int BUTTON_TOTAL  = BUTTON_TOTAL_DEF,
	parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       opcode,
	input  logic [7:0] rx_byte,
	input  logic       event_changed,
	input  logic [7:0] event_button,
	output logic       empty,
	input  logic       pop,
	output logic [3:0] reply_code,
	output logic       led_cmd_valid,
	output logic [2:0] led_cmd,
	output logic [7:0] led_target,
	output logic [7:0] report_id,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);

	logic job_valid;
	job_t front_job;
	logic job_full;
	logic job_take;
	job_t head_job;
	logic job_empty;

	// accept and classify
	alci_front #(
		.LED_TOTAL     (LED_TOTAL),
		.BUTTON_TOTAL  (BUTTON_TOTAL),
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.rx_byte       (rx_byte),
		.event_changed (event_changed),
		.event_button  (event_button),
		.job_valid     (job_valid),
		.job           (front_job),
		.job_full      (job_full)
	);

	// job queue
	alci_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_valid),
		.push_job (front_job),
		.full     (job_full),
		.take     (job_take),
		.head_job (head_job),
		.empty    (job_empty)
	);

	// carry out
	alci_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.job_empty     (job_empty),
		.job           (head_job),
		.job_take      (job_take),
		.empty         (empty),
		.pop           (pop),
		.reply_code    (reply_code),
		.led_cmd_valid (led_cmd_valid),
		.led_cmd       (led_cmd),
		.led_target    (led_target),
		.report_id     (report_id)
	);

endmodule
